[src/vehicle_diag_response_decoder_top_macros.svh]
// Assertion macros for the diagnostic response decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef VEHICLE_DIAG_RESPONSE_DECODER_TOP_MACROS_SVH
`define VEHICLE_DIAG_RESPONSE_DECODER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define VDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define VDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/vdr_pkg.sv]
// Types and constants shared by the diagnostic response decoder modules.
// No dependencies.
`default_nettype none

package vdr_pkg;

  localparam int unsigned VinLen = 17;

  // Item kinds.
  localparam logic [1:0] KIND_FRAME    = 2'd0;
  localparam logic [1:0] KIND_TICK     = 2'd1;
  localparam logic [1:0] KIND_VIN_READ = 2'd2;

  localparam logic [7:0] SEAT_THR_RESET = 8'd24;

  // Identifiers.
  localparam logic [10:0] ID_VIN     = 11'h681;
  localparam logic [10:0] ID_BMS     = 11'h693;
  localparam logic [10:0] ID_ODO_HM  = 11'h683;
  localparam logic [10:0] ID_FRONT   = 11'h6C4;
  localparam logic [10:0] ID_REAR    = 11'h688;
  localparam logic [10:0] ID_SPEED   = 11'h6A9;
  localparam logic [10:0] ID_SPD_RSP = 11'h629;

  // Protocol bytes.
  localparam logic [7:0] PCI_SINGLE = 8'h03;
  localparam logic [7:0] SVC_READ   = 8'h22;
  localparam logic [7:0] PCI_FC     = 8'h30;
  localparam logic [7:0] PCI_CONS1  = 8'h21;
  localparam logic [7:0] PCI_CONS2  = 8'h22;
  localparam logic [7:0] REAR_OCC   = 8'h12;
  localparam logic [7:0] MID_OCC    = 8'h20;

  // Flow-control heads.
  localparam logic [31:0] FC_VIN_HEAD   = 32'h3008F100;
  localparam logic [31:0] FC_SPEED_HEAD = 32'h30000100;

  // Request steps.
  localparam logic [3:0] STEP_IDLE = 4'd0;
  localparam logic [3:0] STEP_VIN  = 4'd1;
  localparam logic [3:0] STEP_LAST = 4'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_id;
    logic        frame_extended;
    logic [7:0]  data0;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [7:0]  data3;
    logic [7:0]  data4;
    logic [7:0]  data5;
    logic [7:0]  data6;
    logic [7:0]  data7;
    logic [4:0]  vin_index;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [31:0] tx_head;
    logic [23:0] odo_km;
    logic [23:0] odo_hundred_m;
    logic [7:0]  charge_level;
    logic [7:0]  health_level;
    logic [7:0]  speed;
    logic        seat_occupied;
    logic        vin_complete;
    logic [7:0]  vin_byte;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [10:0] id;
    logic [31:0] head;
  } tx_t;

  typedef struct packed {
    logic [3:0]              request_step;
    logic [VinLen-1:0][7:0]  vin_store;
    logic                    vin_part_pending;
    logic                    vin_done;
    logic                    speed_part_pending;
    logic                    variant_seat_capable;
    logic [23:0]             odo_km;
    logic [23:0]             odo_hm;
    logic [7:0]              charge;
    logic [7:0]              health;
    logic [7:0]              speed;
    logic [3:0]              seat_flags;
  } dec_state_t;

  // Step result of the request scheduler.
  typedef struct packed {
    tx_t        tx;
    logic [3:0] step_next;
    logic       clr_speed_pending;
  } sched_t;

  function automatic logic [31:0] req_head(logic [7:0] pid, logic [7:0] did);
    return {PCI_SINGLE, SVC_READ, pid, did};
  endfunction

endpackage

`default_nettype wire

[src/vdr_sched.sv]
// Request scheduler: maps the current slot to a request frame head.
// Depends on vdr_pkg.
`default_nettype none

module vdr_sched (
  input  wire logic [3:0]    step_i,
  input  wire logic          vin_done_i,
  input  wire logic          variant_i,
  output vdr_pkg::sched_t    sched_o
);
  import vdr_pkg::*;

  // Slot table; slots past the last one restart the sequence at the VIN slot.
  always_comb begin
    sched_o = '0;
    sched_o.step_next = step_i + 4'd1;
    case (step_i)
      STEP_IDLE: ;
      STEP_VIN: begin
        sched_o.clr_speed_pending = 1'b1;
        if (!vin_done_i) begin
          sched_o.tx = '{valid: 1'b1, id: ID_VIN, head: req_head(8'hF1, 8'h90)};
        end
      end
      4'd2: sched_o.tx = '{valid: 1'b1, id: ID_BMS,    head: req_head(8'hF1, 8'h21)};
      4'd3: sched_o.tx = '{valid: 1'b1, id: ID_ODO_HM, head: req_head(8'hF1, 8'h24)};
      4'd4: sched_o.tx = '{valid: 1'b1, id: ID_BMS,    head: req_head(8'hF0, 8'h26)};
      4'd5: sched_o.tx = '{valid: 1'b1, id: ID_BMS,    head: req_head(8'hF0, 8'h27)};
      4'd6: sched_o.tx = '{valid: 1'b1, id: ID_FRONT,  head: req_head(8'hFA, 8'hC1)};
      4'd7: sched_o.tx = '{valid: 1'b1, id: ID_REAR,   head: req_head(8'h33, 8'h36)};
      4'd8: sched_o.tx = '{valid: 1'b1, id: ID_REAR,   head: req_head(8'h33, 8'h37)};
      4'd9: sched_o.tx = '{valid: 1'b1, id: ID_REAR,   head: req_head(8'h33, 8'h3B)};
      STEP_LAST: begin
        sched_o.tx.valid = 1'b1;
        sched_o.tx.id    = ID_SPEED;
        sched_o.tx.head  = variant_i ? req_head(8'hDD, 8'h09) : req_head(8'h30, 8'h07);
      end
      default: sched_o.step_next = STEP_VIN;
    endcase
  end

endmodule

`default_nettype wire

[src/vdr_frame.sv]
// Frame decoder: computes the state after one received standard frame.
// Depends on vdr_pkg.
`default_nettype none

module vdr_frame (
  input  wire vdr_pkg::in_item_t   item_i,
  input  wire vdr_pkg::dec_state_t st_i,
  input  wire logic [7:0]          seat_thr_i,
  output vdr_pkg::dec_state_t      st_o,
  output vdr_pkg::tx_t             tx_o
);
  import vdr_pkg::*;

  logic [7:0][7:0] d;
  logic [15:0]     raw;
  logic [7:0]      speed_sat;

  assign d = {item_i.data7, item_i.data6, item_i.data5, item_i.data4,
              item_i.data3, item_i.data2, item_i.data1, item_i.data0};

  // Speed is the raw value over 64, saturated to one byte.
  assign raw       = {item_i.data6, item_i.data5};
  assign speed_sat = (raw[15:14] != 2'b00) ? 8'hFF : raw[13:6];

  always_comb begin
    st_o = st_i;
    tx_o = '0;

    // VIN continuation parts.
    if (st_i.vin_part_pending) begin
      if (d[0] == PCI_CONS1) begin
        for (int k = 0; k < 7; k++) st_o.vin_store[3+k] = d[k+1];
      end else if (d[0] == PCI_CONS2) begin
        for (int k = 0; k < 7; k++) st_o.vin_store[10+k] = d[k+1];
        st_o.vin_part_pending = 1'b0;
        st_o.vin_done         = 1'b1;
      end
    end

    // Single-frame and first-frame responses, first match wins.
    if (d[3] == 8'hF1 && d[4] == 8'h90) begin
      st_o.vin_store[0]     = d[5];
      st_o.vin_store[1]     = d[6];
      st_o.vin_store[2]     = d[7];
      st_o.vin_part_pending = 1'b1;
      tx_o = '{valid: 1'b1, id: ID_VIN, head: FC_VIN_HEAD};
    end else if (d[2] == 8'hF1 && d[3] == 8'h21) begin
      st_o.odo_km = {d[4], d[5], d[6]};
    end else if (d[2] == 8'hF1 && d[3] == 8'h24) begin
      st_o.odo_hm = {d[4], d[5], d[6]};
    end else if (d[2] == 8'hF0 && d[3] == 8'h26) begin
      st_o.charge = d[5];
    end else if (d[2] == 8'hF0 && d[3] == 8'h27) begin
      st_o.health = d[5];
    end else if (d[2] == 8'hFA && d[3] == 8'hC1) begin
      st_o.seat_flags[0] = d[5] > seat_thr_i;
    end else if (d[2] == 8'h33 && d[3] == 8'h36) begin
      st_o.variant_seat_capable = 1'b1;
      st_o.seat_flags[1]        = d[4] == REAR_OCC;
    end else if (d[2] == 8'h33 && d[3] == 8'h37) begin
      st_o.seat_flags[2] = d[4] == REAR_OCC;
    end else if (d[2] == 8'h33 && d[3] == 8'h3B) begin
      st_o.seat_flags[3] = d[4] == MID_OCC;
    end else if (d[2] == 8'hDD && d[3] == 8'h09) begin
      st_o.speed = d[4];
    end

    // Multi-frame speed response on its own identifier.
    if (item_i.frame_id == ID_SPD_RSP) begin
      if (d[3] == PCI_FC && d[4] == 8'h07) begin
        tx_o = '{valid: 1'b1, id: ID_SPEED, head: FC_SPEED_HEAD};
        st_o.speed_part_pending = 1'b1;
      end
      if (d[0] == PCI_CONS1 && st_o.speed_part_pending) begin
        st_o.speed              = speed_sat;
        st_o.speed_part_pending = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/vehicle_diag_response_decoder_top.sv]
// Top level of the diagnostic response decoder: input register, state,
// result register and handshakes. Depends on vdr_pkg, vdr_sched, vdr_frame.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) carries one item:
//   a received frame, a scheduler tick or a VIN byte read. Every item yields
//   exactly one result on the output channel (out_valid_o / out_ready_i /
//   out_data_o), carrying an optional request or flow-control frame head
//   and the current decoded values.
//   The block takes one item per cycle while the receiver keeps up. A
//   transfer is held in the input register, and its result is presented from
//   the result register, loaded over the decode path that runs from the
//   input register through the slot table and byte compares. When the
//   receiver stalls, the result register holds its value, the input
//   register fills, and in_ready_o drops until the result moves on. The
//   user writes the seat threshold through cfg_we_i / cfg_wdata_i only
//   while the block is idle; the block does not enforce this. Reset clears
//   all decoded state, the VIN store and both valid flags, and sets the
//   seat threshold to 24.
`default_nettype none

module vehicle_diag_response_decoder_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vdr_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output vdr_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i
);
  import vdr_pkg::*;

  logic        in_vld_q;
  in_item_t    in_q;
  logic        out_vld_q;
  out_item_t   out_q, out_d;
  dec_state_t  st_q, st_d, st_frame;
  logic [7:0]  seat_thr_q;
  sched_t      sched;
  tx_t         tx_frame, tx_d;
  logic        adv;

  // An item moves from the input register to the result register when the
  // result register is empty or being emptied.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  vdr_sched u_sched (
    .step_i     (st_q.request_step),
    .vin_done_i (st_q.vin_done),
    .variant_i  (st_q.variant_seat_capable),
    .sched_o    (sched)
  );

  vdr_frame u_frame (
    .item_i     (in_q),
    .st_i       (st_q),
    .seat_thr_i (seat_thr_q),
    .st_o       (st_frame),
    .tx_o       (tx_frame)
  );

  // Select the state update by item kind.
  always_comb begin
    st_d = st_q;
    tx_d = '0;
    case (in_q.kind)
      KIND_TICK: begin
        st_d.request_step = sched.step_next;
        if (sched.clr_speed_pending) st_d.speed_part_pending = 1'b0;
        tx_d = sched.tx;
      end
      KIND_FRAME: begin
        if (!in_q.frame_extended) begin
          st_d = st_frame;
          tx_d = tx_frame;
        end
      end
      default: ;
    endcase
  end

  // Assemble the result from the updated state.
  always_comb begin
    out_d.tx_valid      = tx_d.valid;
    out_d.tx_id         = tx_d.id;
    out_d.tx_head       = tx_d.head;
    out_d.odo_km        = st_d.odo_km;
    out_d.odo_hundred_m = st_d.odo_hm;
    out_d.charge_level  = st_d.charge;
    out_d.health_level  = st_d.health;
    out_d.speed         = st_d.speed;
    out_d.seat_occupied = st_d.variant_seat_capable && (st_d.seat_flags != 4'd0);
    out_d.vin_complete  = st_d.vin_done;
    out_d.vin_byte      = 8'd0;
    if (in_q.kind == KIND_VIN_READ && in_q.vin_index < 5'(VinLen)) begin
      out_d.vin_byte = st_q.vin_store[in_q.vin_index];
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      st_q       <= '0;
      seat_thr_q <= SEAT_THR_RESET;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) seat_thr_q <= cfg_wdata_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`include "vehicle_diag_response_decoder_top_macros.svh"

  `VDR_ASSERT(a_step_range, st_q.request_step <= 4'd11, "request step out of range")
  `VDR_ASSERT_NEXT(a_vin_done_sticky, st_q.vin_done, st_q.vin_done, "VIN done flag cleared")
  `VDR_ASSERT_NEXT(a_in_hold, in_vld_q && !adv, in_vld_q, "stalled input item lost")
  `VDR_ASSERT(a_tx_id, (out_vld_q && out_q.tx_valid) |-> (out_q.tx_id != '0), "tx id missing")

endmodule

`default_nettype wire

[sim/tb_vehicle_diag_response_decoder_top.sv]
// Self-checking testbench for vehicle_diag_response_decoder_top.
// Drives directed and random frames, ticks and VIN reads over valid/ready channels
// and checks every result against a built-in predictor or its directed row. Depends on vdr_pkg.
`timescale 1ns / 1ps

module tb_vehicle_diag_response_decoder_top;
  import vdr_pkg::*;

  // Item kind with no effect, not named in the package.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Data identifier bytes of the decoded responses.
  localparam logic [7:0] DID_VIN_HI     = 8'hF1;
  localparam logic [7:0] DID_VIN_LO     = 8'h90;
  localparam logic [7:0] DID_ODO_HI     = 8'hF1;
  localparam logic [7:0] DID_ODO_KM     = 8'h21;
  localparam logic [7:0] DID_ODO_HM     = 8'h24;
  localparam logic [7:0] DID_BATT_HI    = 8'hF0;
  localparam logic [7:0] DID_CHARGE     = 8'h26;
  localparam logic [7:0] DID_HEALTH     = 8'h27;
  localparam logic [7:0] DID_SEAT_HI    = 8'hFA;
  localparam logic [7:0] DID_SEAT_FRONT = 8'hC1;
  localparam logic [7:0] DID_REAR_HI    = 8'h33;
  localparam logic [7:0] DID_REAR_LEFT  = 8'h36;
  localparam logic [7:0] DID_REAR_RIGHT = 8'h37;
  localparam logic [7:0] DID_REAR_MID   = 8'h3B;
  localparam logic [7:0] DID_SPEED_HI   = 8'hDD;
  localparam logic [7:0] DID_SPEED_LO   = 8'h09;
  localparam logic [7:0] DID_SPD_ALT_LO = 8'h07;
  localparam logic [7:0] PCI_FIRST      = 8'h10;

  // Scheduler slots between the VIN request and the speed request.
  localparam logic [3:0] SLOT_ODO_KM  = 4'd2;
  localparam logic [3:0] SLOT_ODO_HM  = 4'd3;
  localparam logic [3:0] SLOT_CHARGE  = 4'd4;
  localparam logic [3:0] SLOT_HEALTH  = 4'd5;
  localparam logic [3:0] SLOT_FRONT   = 4'd6;
  localparam logic [3:0] SLOT_REAR_L  = 4'd7;
  localparam logic [3:0] SLOT_REAR_R  = 4'd8;
  localparam logic [3:0] SLOT_REAR_M  = 4'd9;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  in_item_t   in_data = '0;
  logic       out_ready = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  // Predicted decoder state.
  logic [3:0]  dm_step = '0;
  logic [7:0]  dm_vin [VinLen];
  logic        dm_vin_pending = 1'b0;
  logic        dm_vin_done = 1'b0;
  logic        dm_speed_pending = 1'b0;
  logic        dm_seat_capable = 1'b0;
  logic [23:0] dm_odo_km = '0;
  logic [23:0] dm_odo_hm = '0;
  logic [7:0]  dm_charge = '0;
  logic [7:0]  dm_health = '0;
  logic [7:0]  dm_speed = '0;
  logic [3:0]  dm_seat_flags = '0;
  logic [7:0]  dm_seat_thr = SEAT_THR_RESET;

  out_item_t expected_results [$];
  stim_row_t directed_rows [$];

  int mismatch_count = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int ticks_sent = 0;
  int reads_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  vehicle_diag_response_decoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Request frame head with the single-frame length byte and read service.
  function automatic tx_t request_tx(logic [10:0] id, logic [7:0] pid, logic [7:0] did);
    tx_t t;
    t.valid = 1'b1;
    t.id    = id;
    t.head  = {PCI_SINGLE, SVC_READ, pid, did};
    return t;
  endfunction

  // Advances the predicted state by one item and returns the expected result.
  function automatic out_item_t predict_response(in_item_t it);
    out_item_t   r;
    logic [3:0]  slot;
    logic [63:0] db;
    logic [15:0] raw;
    logic [9:0]  scaled;
    r  = '0;
    db = {it.data0, it.data1, it.data2, it.data3, it.data4, it.data5, it.data6, it.data7};
    case (it.kind)
      KIND_TICK: begin
        slot = dm_step;
        case (slot)
          STEP_IDLE: ;
          STEP_VIN: begin
            dm_speed_pending = 1'b0;
            if (!dm_vin_done) begin
              {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_VIN, DID_VIN_HI, DID_VIN_LO);
            end
          end
          SLOT_ODO_KM: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_BMS, DID_ODO_HI, DID_ODO_KM);
          end
          SLOT_ODO_HM: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_ODO_HM, DID_ODO_HI, DID_ODO_HM);
          end
          SLOT_CHARGE: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_BMS, DID_BATT_HI, DID_CHARGE);
          end
          SLOT_HEALTH: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_BMS, DID_BATT_HI, DID_HEALTH);
          end
          SLOT_FRONT: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_FRONT, DID_SEAT_HI, DID_SEAT_FRONT);
          end
          SLOT_REAR_L: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_REAR, DID_REAR_HI, DID_REAR_LEFT);
          end
          SLOT_REAR_R: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_REAR, DID_REAR_HI, DID_REAR_RIGHT);
          end
          SLOT_REAR_M: begin
            {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_REAR, DID_REAR_HI, DID_REAR_MID);
          end
          STEP_LAST: begin
            if (dm_seat_capable) begin
              {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_SPEED, DID_SPEED_HI, DID_SPEED_LO);
            end else begin
              {r.tx_valid, r.tx_id, r.tx_head} = request_tx(ID_SPEED, PCI_FC, DID_SPD_ALT_LO);
            end
          end
          default: slot = STEP_IDLE;
        endcase
        dm_step = slot + 4'd1;
      end
      KIND_FRAME: begin
        if (!it.frame_extended) begin
          // VIN continuation parts come first.
          if (dm_vin_pending) begin
            if (it.data0 == PCI_CONS1) begin
              for (int i = 1; i < 8; i++) dm_vin[2 + i] = db[63 - 8 * i -: 8];
            end else if (it.data0 == PCI_CONS2) begin
              for (int i = 1; i < 8; i++) dm_vin[9 + i] = db[63 - 8 * i -: 8];
              dm_vin_pending = 1'b0;
              dm_vin_done    = 1'b1;
            end
          end
          // First matching response identifier wins.
          if (it.data3 == DID_VIN_HI && it.data4 == DID_VIN_LO) begin
            dm_vin[0] = it.data5;
            dm_vin[1] = it.data6;
            dm_vin[2] = it.data7;
            dm_vin_pending = 1'b1;
            {r.tx_valid, r.tx_id, r.tx_head} = {1'b1, ID_VIN, FC_VIN_HEAD};
          end else if (it.data2 == DID_ODO_HI && it.data3 == DID_ODO_KM) begin
            dm_odo_km = {it.data4, it.data5, it.data6};
          end else if (it.data2 == DID_ODO_HI && it.data3 == DID_ODO_HM) begin
            dm_odo_hm = {it.data4, it.data5, it.data6};
          end else if (it.data2 == DID_BATT_HI && it.data3 == DID_CHARGE) begin
            dm_charge = it.data5;
          end else if (it.data2 == DID_BATT_HI && it.data3 == DID_HEALTH) begin
            dm_health = it.data5;
          end else if (it.data2 == DID_SEAT_HI && it.data3 == DID_SEAT_FRONT) begin
            dm_seat_flags[0] = (it.data5 > dm_seat_thr);
          end else if (it.data2 == DID_REAR_HI && it.data3 == DID_REAR_LEFT) begin
            dm_seat_capable  = 1'b1;
            dm_seat_flags[1] = (it.data4 == REAR_OCC);
          end else if (it.data2 == DID_REAR_HI && it.data3 == DID_REAR_RIGHT) begin
            dm_seat_flags[2] = (it.data4 == REAR_OCC);
          end else if (it.data2 == DID_REAR_HI && it.data3 == DID_REAR_MID) begin
            dm_seat_flags[3] = (it.data4 == MID_OCC);
          end else if (it.data2 == DID_SPEED_HI && it.data3 == DID_SPEED_LO) begin
            dm_speed = it.data4;
          end
          // Two-part speed response on its own identifier.
          if (it.frame_id == ID_SPD_RSP) begin
            if (it.data3 == PCI_FC && it.data4 == DID_SPD_ALT_LO) begin
              {r.tx_valid, r.tx_id, r.tx_head} = {1'b1, ID_SPEED, FC_SPEED_HEAD};
              dm_speed_pending = 1'b1;
            end
            if (it.data0 == PCI_CONS1 && dm_speed_pending) begin
              raw    = {it.data6, it.data5};
              scaled = raw[15:6];
              dm_speed = (scaled > 10'd255) ? 8'hFF : scaled[7:0];
              dm_speed_pending = 1'b0;
            end
          end
        end
      end
      KIND_VIN_READ: begin
        if (it.vin_index < VinLen) r.vin_byte = dm_vin[it.vin_index];
      end
      default: ;
    endcase
    r.odo_km        = dm_odo_km;
    r.odo_hundred_m = dm_odo_hm;
    r.charge_level  = dm_charge;
    r.health_level  = dm_health;
    r.speed         = dm_speed;
    r.seat_occupied = dm_seat_capable && (dm_seat_flags != 4'd0);
    r.vin_complete  = dm_vin_done;
    return r;
  endfunction

  function automatic in_item_t frame_item(logic [10:0] id, logic [63:0] bytes);
    in_item_t it;
    it = '0;
    it.kind     = KIND_FRAME;
    it.frame_id = id;
    {it.data0, it.data1, it.data2, it.data3, it.data4, it.data5, it.data6, it.data7} = bytes;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = '0;
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, logic typed, out_item_t want);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Random item: mostly well-formed responses and ticks, some reads and noise.
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [95:0] noise;
    int          pick;
    noise = {$urandom(), $urandom(), $urandom()};
    it    = noise[$bits(in_item_t)-1:0];
    pick  = $urandom_range(0, 99);
    if (pick < 22) begin
      it.kind = KIND_TICK;
    end else if (pick < 34) begin
      it.kind = KIND_VIN_READ;
      if ($urandom_range(0, 3) != 0) it.vin_index = 5'($urandom_range(0, VinLen - 1));
    end else if (pick < 37) begin
      it.kind = KIND_UNUSED;
    end else begin
      it.kind = KIND_FRAME;
      it.frame_extended = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 14))
        0: begin
          it.data0 = PCI_FIRST;
          {it.data3, it.data4} = {DID_VIN_HI, DID_VIN_LO};
        end
        1: it.data0 = PCI_CONS1;
        2: it.data0 = PCI_CONS2;
        3: {it.data2, it.data3} = {DID_ODO_HI, DID_ODO_KM};
        4: {it.data2, it.data3} = {DID_ODO_HI, DID_ODO_HM};
        5: {it.data2, it.data3} = {DID_BATT_HI, DID_CHARGE};
        6: {it.data2, it.data3} = {DID_BATT_HI, DID_HEALTH};
        7: {it.data2, it.data3} = {DID_SEAT_HI, DID_SEAT_FRONT};
        8: begin
          {it.data2, it.data3} = {DID_REAR_HI, DID_REAR_LEFT};
          if ($urandom_range(0, 1) != 0) it.data4 = REAR_OCC;
        end
        9: begin
          {it.data2, it.data3} = {DID_REAR_HI, DID_REAR_RIGHT};
          if ($urandom_range(0, 1) != 0) it.data4 = REAR_OCC;
        end
        10: begin
          {it.data2, it.data3} = {DID_REAR_HI, DID_REAR_MID};
          if ($urandom_range(0, 1) != 0) it.data4 = MID_OCC;
        end
        11: {it.data2, it.data3} = {DID_SPEED_HI, DID_SPEED_LO};
        12: begin
          it.frame_id = ID_SPD_RSP;
          it.data0    = PCI_FIRST;
          {it.data3, it.data4} = {PCI_FC, DID_SPD_ALT_LO};
        end
        13: begin
          it.frame_id = ID_SPD_RSP;
          it.data0    = PCI_CONS1;
          // Keep some raw speeds below the saturation point.
          if ($urandom_range(0, 1) != 0) it.data6 = 8'($urandom_range(0, 63));
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch on result %0d: %s got %0h, expected %0h",
               results_seen, what, got, want);
    end
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.tx_valid !== want.tx_valid) report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
    if (got.tx_id !== want.tx_id) report_mismatch("tx_id", got.tx_id, want.tx_id);
    if (got.tx_head !== want.tx_head) report_mismatch("tx_head", got.tx_head, want.tx_head);
    if (got.odo_km !== want.odo_km) report_mismatch("odo_km", got.odo_km, want.odo_km);
    if (got.odo_hundred_m !== want.odo_hundred_m) begin
      report_mismatch("odo_hundred_m", got.odo_hundred_m, want.odo_hundred_m);
    end
    if (got.charge_level !== want.charge_level) begin
      report_mismatch("charge_level", got.charge_level, want.charge_level);
    end
    if (got.health_level !== want.health_level) begin
      report_mismatch("health_level", got.health_level, want.health_level);
    end
    if (got.speed !== want.speed) report_mismatch("speed", got.speed, want.speed);
    if (got.seat_occupied !== want.seat_occupied) begin
      report_mismatch("seat_occupied", got.seat_occupied, want.seat_occupied);
    end
    if (got.vin_complete !== want.vin_complete) begin
      report_mismatch("vin_complete", got.vin_complete, want.vin_complete);
    end
    if (got.vin_byte !== want.vin_byte) report_mismatch("vin_byte", got.vin_byte, want.vin_byte);
  endtask

  // Offers one item and waits for its transfer. Entered and left at a falling edge.
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready_o);
    predicted = predict_response(it);
    expected_results.push_back(typed ? want : predicted);
    case (it.kind)
      KIND_FRAME:    frames_sent++;
      KIND_TICK:     ticks_sent++;
      KIND_VIN_READ: reads_sent++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits until every result has arrived, then idles before returning.
  task automatic wait_idle();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    dm_seat_thr = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, and a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: each output transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", out_data_o.tx_head, '0);
      end else begin
        check_result(out_data_o, expected_results.pop_front());
      end
    end
  end

  initial begin
    out_item_t  w;
    logic [7:0] thresholds [3];
    int         phase_items [3];
    in_item_t   odd;

    for (int i = 0; i < VinLen; i++) dm_vin[i] = '0;

    // Directed rows: reset values, the full slot sequence, each response and special cases.
    add_row(tick_item(), 1'b1, '0);
    w = '0;
    {w.tx_valid, w.tx_id, w.tx_head} = {1'b1, ID_VIN, 32'h0322F190};
    add_row(tick_item(), 1'b1, w);
    for (int s = 2; s <= 11; s++) add_row(tick_item(), 1'b0, '0);
    w = '0;
    {w.tx_valid, w.tx_id, w.tx_head} = {1'b1, ID_VIN, FC_VIN_HEAD};
    add_row(frame_item(11'h689, 64'h10_14_62_F1_90_4C_53_56), 1'b1, w);
    add_row(frame_item(11'h689, 64'h21_31_32_33_34_35_36_37), 1'b0, '0);
    add_row(frame_item(11'h689, 64'h22_38_39_41_42_43_44_45), 1'b0, '0);
    odd = '0;
    odd.kind      = KIND_VIN_READ;
    odd.vin_index = 5'h1F;
    add_row(odd, 1'b0, '0);
    add_row(frame_item(11'h69B, 64'h07_62_F1_21_FF_FF_FF_AA), 1'b0, '0);
    add_row(frame_item(11'h68B, 64'h07_62_F1_24_00_00_01_55), 1'b0, '0);
    add_row(frame_item(11'h69B, 64'h07_62_F0_26_00_FF_00_00), 1'b0, '0);
    add_row(frame_item(11'h69B, 64'h07_62_F0_27_00_00_00_00), 1'b0, '0);
    // Front seat set while the variant is still unknown: no occupancy shown.
    add_row(frame_item(11'h6CC, 64'h07_62_FA_C1_00_19_00_00), 1'b0, '0);
    add_row(frame_item(11'h690, 64'h07_62_33_36_12_00_00_00), 1'b0, '0);
    add_row(frame_item(11'h690, 64'h07_62_33_37_11_00_00_00), 1'b0, '0);
    add_row(frame_item(11'h690, 64'h07_62_33_3B_20_00_00_00), 1'b0, '0);
    add_row(frame_item(11'h6B1, 64'h07_62_DD_09_FF_00_00_00), 1'b0, '0);
    add_row(frame_item(ID_SPD_RSP, 64'h10_0A_62_30_07_00_00_00), 1'b0, '0);
    // Largest raw speed saturates.
    add_row(frame_item(ID_SPD_RSP, 64'h21_00_00_00_00_FF_FF_00), 1'b0, '0);
    odd = frame_item(11'h69B, 64'h07_62_F1_21_12_34_56_00);
    odd.frame_extended = 1'b1;
    add_row(odd, 1'b0, '0);
    odd = '1;
    odd.kind = KIND_UNUSED;
    add_row(odd, 1'b0, '0);

    // Hold reset, then release it at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 68;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    in_valid <= 1'b0;

    // Random phases: threshold extremes and a random one, with shifting idle patterns.
    thresholds  = '{8'h00, 8'hFF, 8'($urandom_range(0, 255))};
    phase_items = '{170, 170, 160};
    for (int p = 0; p < 3; p++) begin
      wait_idle();
      write_threshold(thresholds[p]);
      case (p)
        0: begin send_idle_pct = 23; recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 23; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      repeat (phase_items[p]) send_item(random_item(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    wait_idle();
    $display("Sent %0d frames, %0d ticks and %0d VIN reads; checked %0d results.",
             frames_sent, ticks_sent, reads_sent, results_seen);
    $display("Seat thresholds 24, 0, 255 and %0d; %0d mismatches.", thresholds[2],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[vehicle_diag_response_decoder_top.f]
+incdir+src
src/vdr_pkg.sv
src/vdr_sched.sv
src/vdr_frame.sv
src/vehicle_diag_response_decoder_top.sv
sim/tb_vehicle_diag_response_decoder_top.sv
